[design/dff_pkg.sv]
// Shared constants, types and the BCD conversion step for the decimal field formatter.
`timescale 1ns / 1ps

package dff_pkg;

  localparam int MAX_FIELD_WIDTH_DEF = 16;
  localparam int NUM_DIGITS          = 10;
  localparam int BCD_W               = 4 * NUM_DIGITS;
  localparam int BIN_W               = 32;
  localparam int BITS_PER_STAGE      = 8;
  localparam int CONV_STAGES         = BIN_W / BITS_PER_STAGE;

  localparam logic OP_EDIT    = 1'b0;
  localparam logic OP_PICTURE = 1'b1;

  localparam logic [7:0] CH_BLANK = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef logic [BCD_W-1:0] bcd_t;
  typedef logic [BCD_W+BIN_W-1:0] dabble_t;

  // Eight shift-and-add-3 steps of the double dabble conversion.
  function automatic dabble_t dabble8(input dabble_t acc);
    dabble_t r;
    r = acc;
    for (int k = 0; k < BITS_PER_STAGE; k++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (r[BIN_W+4*d +: 4] >= 4'd5) begin
          r[BIN_W+4*d +: 4] = r[BIN_W+4*d +: 4] + 4'd3;
        end
      end
      r = r << 1;
    end
    return r;
  endfunction

  // Decimal digit at a position counted from the right; zero beyond the tenth.
  function automatic logic [3:0] digit_at(input bcd_t bcd, input logic [3:0] idx);
    logic [3:0] d;
    case (idx)
      4'd0:    d = bcd[3:0];
      4'd1:    d = bcd[7:4];
      4'd2:    d = bcd[11:8];
      4'd3:    d = bcd[15:12];
      4'd4:    d = bcd[19:16];
      4'd5:    d = bcd[23:20];
      4'd6:    d = bcd[27:24];
      4'd7:    d = bcd[31:28];
      4'd8:    d = bcd[35:32];
      4'd9:    d = bcd[39:36];
      default: d = 4'd0;
    endcase
    return d;
  endfunction

endpackage

[design/decimal_field_formatter_unit.sv]
// Top level of the decimal field formatter: binary to fixed-width ASCII decimal field.
`timescale 1ns / 1ps

// Each request carries a signed 32-bit value, a field width and a mode, and
// produces one ASCII character per cycle on the output when it is not stalled,
// leftmost first, with last set on the final one. Edit mode right-justifies
// the signed decimal text with blanks and keeps its leftmost characters when
// it is too long; picture mode zero-pads the magnitude and keeps its rightmost
// digits. Widths above MAX_FIELD_WIDTH saturate, and a request of width zero
// is taken and produces nothing. Requests flow through an input register, four
// double dabble stages of eight bits each, a digit count stage, a character
// sequencer and an output register. The sequencer emits one character per
// cycle unless the output stalls, w characters for a request of width w, and
// new requests keep entering the pipeline meanwhile.
module decimal_field_formatter_unit
  import dff_pkg::*;
#(
  parameter int MAX_FIELD_WIDTH = MAX_FIELD_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             op,
  input  logic signed [31:0] value,
  input  logic [4:0]       width,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       char_out,
  output logic             last
);

  localparam int WW = $clog2(MAX_FIELD_WIDTH + 1);
  localparam int LW = 4;

  // Input stage.
  logic            a_valid;
  logic            a_op;
  logic            a_neg;
  logic [BIN_W-1:0] a_mag;
  logic [WW-1:0]   a_w;

  // Conversion stages.
  logic [CONV_STAGES-1:0] dd_valid;
  logic            dd_op    [CONV_STAGES];
  logic            dd_neg   [CONV_STAGES];
  logic [WW-1:0]   dd_w     [CONV_STAGES];
  dabble_t         dd_acc   [CONV_STAGES];

  // Digit count stage.
  logic            c_valid;
  logic            c_op;
  logic            c_neg;
  bcd_t            c_bcd;
  logic [LW-1:0]   c_nd;
  logic [WW-1:0]   c_q;
  logic [WW-1:0]   c_w;

  // Character sequencer.
  logic            e_busy;
  logic            e_op;
  logic            e_neg;
  bcd_t            e_bcd;
  logic [LW-1:0]   e_nd;
  logic [WW-1:0]   e_q;
  logic [WW-1:0]   e_rem;

  logic                   out_ready;
  logic                   e_fire;
  logic                   e_ready;
  logic                   c_ready;
  logic [CONV_STAGES-1:0] dd_ready;
  logic                   a_ready;

  logic [LW-1:0] nd_next;
  logic [LW-1:0] len_next;
  logic [WW-1:0] q_next;
  bcd_t          tail_bcd;
  logic [7:0]    ch_next;
  logic [3:0]    e_digit;

  // Backpressure chain, from the output back to the input.
  assign out_ready = !out_valid || !out_stall;
  assign e_fire    = e_busy && out_ready;
  assign e_ready   = !e_busy || (e_fire && (e_rem == WW'(1)));
  assign c_ready   = !c_valid || e_ready;

  always_comb begin
    dd_ready[CONV_STAGES-1] = !dd_valid[CONV_STAGES-1] || c_ready;
    for (int k = CONV_STAGES - 2; k >= 0; k--) begin
      dd_ready[k] = !dd_valid[k] || dd_ready[k+1];
    end
  end

  assign a_ready  = !a_valid || dd_ready[0];
  assign in_stall = !a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      // A request of width zero is taken but produces no characters.
      a_valid <= in_valid && (width != 5'd0);
    end
    if (a_ready) begin
      a_op  <= op;
      a_neg <= value[31];
      a_mag <= value[31] ? (~value + 32'd1) : value;
      a_w   <= (width > 5'(MAX_FIELD_WIDTH)) ? WW'(MAX_FIELD_WIDTH) : WW'(width);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dd_valid <= '0;
    end else begin
      if (dd_ready[0]) begin
        dd_valid[0] <= a_valid;
      end
      for (int k = 1; k < CONV_STAGES; k++) begin
        if (dd_ready[k]) begin
          dd_valid[k] <= dd_valid[k-1];
        end
      end
    end
    if (dd_ready[0]) begin
      dd_op[0]  <= a_op;
      dd_neg[0] <= a_neg;
      dd_w[0]   <= a_w;
      dd_acc[0] <= dabble8({{BCD_W{1'b0}}, a_mag});
    end
    for (int k = 1; k < CONV_STAGES; k++) begin
      if (dd_ready[k]) begin
        dd_op[k]  <= dd_op[k-1];
        dd_neg[k] <= dd_neg[k-1];
        dd_w[k]   <= dd_w[k-1];
        dd_acc[k] <= dabble8(dd_acc[k-1]);
      end
    end
  end

  // Significant digit count, text length and the starting position of the
  // character sequence, counted from the right of the digit string.
  always_comb begin
    tail_bcd = dd_acc[CONV_STAGES-1][BIN_W +: BCD_W];
    nd_next  = LW'(1);
    for (int d = 1; d < NUM_DIGITS; d++) begin
      if (tail_bcd[4*d +: 4] != 4'd0) begin
        nd_next = LW'(d + 1);
      end
    end
    len_next = nd_next + LW'(dd_neg[CONV_STAGES-1]);
    if ((dd_op[CONV_STAGES-1] == OP_EDIT) &&
        (WW'(len_next) > dd_w[CONV_STAGES-1])) begin
      q_next = WW'(len_next) - WW'(1);
    end else begin
      q_next = dd_w[CONV_STAGES-1] - WW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= dd_valid[CONV_STAGES-1];
    end
    if (c_ready) begin
      c_op  <= dd_op[CONV_STAGES-1];
      c_neg <= dd_neg[CONV_STAGES-1];
      c_bcd <= tail_bcd;
      c_nd  <= nd_next;
      c_q   <= q_next;
      c_w   <= dd_w[CONV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_busy <= 1'b0;
    end else if (e_ready) begin
      e_busy <= c_valid;
    end
    if (e_ready) begin
      e_op  <= c_op;
      e_neg <= c_neg;
      e_bcd <= c_bcd;
      e_nd  <= c_nd;
      e_q   <= c_q;
      e_rem <= c_w;
    end else if (e_fire) begin
      e_q   <= e_q - WW'(1);
      e_rem <= e_rem - WW'(1);
    end
  end

  // Character at the current position.
  assign e_digit = digit_at(e_bcd, e_q[3:0]);

  always_comb begin
    if (e_op == OP_PICTURE) begin
      if (e_q < WW'(NUM_DIGITS)) begin
        ch_next = CH_ZERO + {4'd0, e_digit};
      end else begin
        ch_next = CH_ZERO;
      end
    end else begin
      if (e_q < WW'(e_nd)) begin
        ch_next = CH_ZERO + {4'd0, e_digit};
      end else if (e_neg && (e_q == WW'(e_nd))) begin
        ch_next = CH_MINUS;
      end else begin
        ch_next = CH_BLANK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= e_busy;
    end
    if (e_fire) begin
      char_out <= ch_next;
      last     <= (e_rem == WW'(1));
    end
  end

endmodule
